FILE: design/stl_pkg.sv
// Shared types, character codes and keyword tables for the source text lexer.
// Depends on nothing; imported by source_text_lexer.
package stl_pkg;

   // Numeric accumulator: values saturate at 2^(VALUE_BITS-1)-1
   localparam int VALUE_BITS = 32;
   localparam int NUM_BITS   = VALUE_BITS - 1;
   localparam int OUT_BITS   = 32;

   localparam logic [31:0] HASH_START = 32'd5381;

   // Result queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   // Characters with a role of their own
   localparam logic [7:0] CH_END     = 8'h00;
   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_SEMI    = 8'h3B;
   localparam logic [7:0] CH_SLASH   = 8'h2F;
   localparam logic [7:0] CH_DOT     = 8'h2E;
   localparam logic [7:0] CH_ZERO    = 8'h30;

   // Word codes
   localparam logic [3:0] CODE_LPAREN = 4'd4;
   localparam logic [3:0] CODE_RPAREN = 4'd5;
   localparam logic [3:0] CODE_LBRACE = 4'd6;
   localparam logic [3:0] CODE_RBRACE = 4'd7;
   localparam logic [3:0] CODE_LBRACK = 4'd8;
   localparam logic [3:0] CODE_RBRACK = 4'd9;
   localparam logic [3:0] CODE_PLUS   = 4'd10;
   localparam logic [3:0] CODE_MINUS  = 4'd11;
   localparam logic [3:0] CODE_STAR   = 4'd12;
   localparam logic [3:0] CODE_DIVIDE = 4'd13;
   localparam logic [3:0] CODE_ASSIGN = 4'd14;

   // Keywords: void, while, for, if, int
   localparam int KW_COUNT = 5;
   localparam logic [7:0] KW_TEXT [0:KW_COUNT-1][0:7] = '{
      '{8'h76, 8'h6F, 8'h69, 8'h64, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h77, 8'h68, 8'h69, 8'h6C, 8'h65, 8'h00, 8'h00, 8'h00},
      '{8'h66, 8'h6F, 8'h72, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h69, 8'h66, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h69, 8'h6E, 8'h74, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
   };
   localparam logic [2:0] KW_LEN  [0:KW_COUNT-1] = '{3'd4, 3'd5, 3'd3, 3'd2, 3'd3};
   localparam logic [3:0] KW_CODE [0:KW_COUNT-1] = '{4'd0, 4'd1, 4'd2, 4'd3, 4'd15};

   typedef enum logic [2:0] {
      MODE_IDLE    = 3'd0,
      MODE_KEYWORD = 3'd1,
      MODE_IDENT   = 3'd2,
      MODE_INT     = 3'd3,
      MODE_DEC     = 3'd4,
      MODE_SLASH   = 3'd5,
      MODE_SEMI    = 3'd6,
      MODE_COMMENT = 3'd7
   } lex_mode_type;

   typedef enum logic [2:0] {
      FORM_WORD  = 3'd0,
      FORM_IDENT = 3'd1,
      FORM_INT   = 3'd2,
      FORM_DEC   = 3'd3,
      FORM_ERROR = 3'd4,
      FORM_END   = 3'd5
   } form_type;

   typedef struct packed {
      form_type              form;
      logic [OUT_BITS-1:0]   value;
      logic                  last;
   } result_type;

   function automatic logic is_letter(input logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   // djb2 step: h*33 + c, wrapping at 32 bits
   function automatic logic [31:0] hash_step(input logic [31:0] h, input logic [7:0] c);
      return (h << 5) + h + {24'd0, c};
   endfunction

   // n*10 + d, saturating at the numeric limit
   function automatic logic [NUM_BITS-1:0] digit_step(input logic [NUM_BITS-1:0] n,
                                                      input logic [7:0] c);
      logic [NUM_BITS+3:0] wide;
      logic [3:0]          d;
      d    = 4'(c - CH_ZERO);
      wide = ({4'd0, n} << 3) + ({4'd0, n} << 1) + (NUM_BITS+4)'(d);
      if (wide[NUM_BITS+3:NUM_BITS] != 4'd0)
         return '1;
      return wide[NUM_BITS-1:0];
   endfunction

   // Single-byte symbols; hit flag in the top bit, code below
   function automatic logic [4:0] symbol_lookup(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      case (c)
         8'h28:   r = {1'b1, CODE_LPAREN};
         8'h29:   r = {1'b1, CODE_RPAREN};
         8'h7B:   r = {1'b1, CODE_LBRACE};
         8'h7D:   r = {1'b1, CODE_RBRACE};
         8'h5B:   r = {1'b1, CODE_LBRACK};
         8'h5D:   r = {1'b1, CODE_RBRACK};
         8'h2B:   r = {1'b1, CODE_PLUS};
         8'h2D:   r = {1'b1, CODE_MINUS};
         8'h2A:   r = {1'b1, CODE_STAR};
         8'h3D:   r = {1'b1, CODE_ASSIGN};
         default: r = 5'd0;
      endcase
      return r;
   endfunction

endpackage

FILE: design/source_text_lexer.sv
// Source text lexer top level: byte-at-a-time tokenizer with a small result queue.
// Depends on stl_pkg (types, character codes, keyword tables, step functions).
//
// Usage:
//   req_valid/req_stall/req_ch carries one source byte per beat; byte 0 ends
//   the text, flushes any pending token and returns the lexer to idle.
//   rsp_valid/rsp_stall carries result beats (rsp_form, rsp_value, rsp_last);
//   rsp_last marks the final result caused by one input byte. A byte causes
//   zero, one or two results.
//   Results are written to the queue when the byte is accepted and reach
//   rsp_* from its head. Throughput: one byte per cycle while req_stall is
//   low. The lexer state is updated in the same cycle the byte is accepted,
//   and results go to a four-entry queue. req_stall rises while fewer than
//   two queue slots are free, so a receiver that stalls fills the queue and
//   then holds off the sender; a byte that causes two results takes two slots.
//   Reset (synchronous, active high) returns the lexer to idle between tokens
//   and empties the queue.
module source_text_lexer (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [7:0]                    req_ch,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output stl_pkg::form_type             rsp_form,
   output logic [stl_pkg::OUT_BITS-1:0]  rsp_value,
   output logic                          rsp_last
);
   import stl_pkg::*;

   // Lexer state
   lex_mode_type          mode_ff,  mode_in;
   logic [KW_COUNT-1:0]   alive_ff, alive_in;
   logic [2:0]            pos_ff,   pos_in;
   logic [31:0]           hash_ff,  hash_in;
   logic [NUM_BITS-1:0]   num_ff,   num_in;

   // Result queue
   result_type            queue_ff [0:QUEUE_DEPTH-1];
   logic [QPTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0]  count_ff,  count_in;

   logic                  req_take;
   logic                  rsp_take;

   // Token start decode
   lex_mode_type          st_mode;
   logic [KW_COUNT-1:0]   st_alive;
   logic [2:0]            st_pos;
   logic [31:0]           st_hash;
   logic [NUM_BITS-1:0]   st_num;
   logic                  st_emit;
   form_type              st_form;
   logic [3:0]            st_code;

   // Pending token flush
   logic                  fl_emit;
   form_type              fl_form;
   logic [OUT_BITS-1:0]   fl_value;

   // Step results
   logic                  use_flush;
   logic                  sec_emit;
   form_type              sec_form;
   logic [OUT_BITS-1:0]   sec_value;
   result_type            res_a, res_b;
   logic [1:0]            push_n;

   assign req_take  = req_valid && !req_stall;
   assign rsp_take  = rsp_valid && !rsp_stall;
   assign req_stall = count_ff > QCNT_BITS'(QUEUE_DEPTH - 2);

   // Decode of a byte that opens a token
   always_comb begin
      logic [4:0] sym;
      logic [KW_COUNT-1:0] first;
      sym      = symbol_lookup(req_ch);
      first    = '0;
      st_mode  = MODE_IDLE;
      st_alive = '0;
      st_pos   = 3'd0;
      st_hash  = HASH_START;
      st_num   = '0;
      st_emit  = 1'b0;
      st_form  = FORM_ERROR;
      st_code  = 4'd0;
      for (int i = 0; i < KW_COUNT; i++)
         first[i] = (KW_TEXT[i][0] == req_ch);
      if (req_ch == CH_SPACE || req_ch == CH_NEWLINE) begin
         st_mode = MODE_IDLE;
      end else if (req_ch == CH_SEMI) begin
         st_mode = MODE_SEMI;
      end else if (req_ch == CH_SLASH) begin
         st_mode = MODE_SLASH;
      end else if (sym[4]) begin
         st_emit = 1'b1;
         st_form = FORM_WORD;
         st_code = sym[3:0];
      end else if (is_letter(req_ch)) begin
         st_hash  = hash_step(HASH_START, req_ch);
         st_alive = first;
         st_pos   = 3'd1;
         st_mode  = (first != '0) ? MODE_KEYWORD : MODE_IDENT;
      end else if (is_digit(req_ch)) begin
         st_num  = digit_step('0, req_ch);
         st_mode = MODE_INT;
      end else begin
         st_emit = 1'b1;
         st_form = FORM_ERROR;
      end
   end

   // What the current mode emits when its token ends
   always_comb begin
      fl_emit  = 1'b1;
      fl_form  = FORM_ERROR;
      fl_value = '0;
      unique case (mode_ff)
         MODE_KEYWORD, MODE_IDENT: begin
            fl_form  = FORM_IDENT;
            fl_value = OUT_BITS'(hash_ff);
         end
         MODE_INT: begin
            fl_form  = FORM_INT;
            fl_value = OUT_BITS'(num_ff);
         end
         MODE_DEC: begin
            fl_form  = FORM_DEC;
            fl_value = OUT_BITS'(num_ff);
         end
         MODE_SLASH: begin
            fl_form  = FORM_WORD;
            fl_value = OUT_BITS'(CODE_DIVIDE);
         end
         MODE_SEMI: begin
            fl_form  = FORM_ERROR;
         end
         default: begin
            fl_emit  = 1'b0;
         end
      endcase
   end

   // One lexing step: next state and up to two results
   always_comb begin
      logic                take_start;
      logic                go_idle;
      logic                kw_done;
      logic [3:0]          kw_code;
      logic [KW_COUNT-1:0] kw_alive;
      take_start = 1'b0;
      go_idle    = 1'b0;
      kw_done    = 1'b0;
      kw_code    = 4'd0;
      kw_alive   = '0;
      mode_in    = mode_ff;
      alive_in   = alive_ff;
      pos_in     = pos_ff;
      hash_in    = hash_ff;
      num_in     = num_ff;
      use_flush  = 1'b0;
      sec_emit   = 1'b0;
      sec_form   = FORM_END;
      sec_value  = '0;

      if (req_ch == CH_END) begin
         use_flush = 1'b1;
         sec_emit  = 1'b1;
         sec_form  = FORM_END;
         go_idle   = 1'b1;
      end else begin
         unique case (mode_ff)
            MODE_KEYWORD: begin
               if (is_letter(req_ch)) begin
                  hash_in = hash_step(hash_ff, req_ch);
                  // Follow surviving keywords; the first one completed wins
                  for (int i = 0; i < KW_COUNT; i++) begin
                     if (!kw_done && alive_ff[i] && pos_ff < KW_LEN[i]
                         && KW_TEXT[i][pos_ff] == req_ch) begin
                        kw_alive[i] = 1'b1;
                        if (pos_ff + 3'd1 == KW_LEN[i]) begin
                           kw_done = 1'b1;
                           kw_code = KW_CODE[i];
                        end
                     end
                  end
                  if (kw_done) begin
                     sec_emit  = 1'b1;
                     sec_form  = FORM_WORD;
                     sec_value = OUT_BITS'(kw_code);
                     go_idle   = 1'b1;
                  end else if (kw_alive != '0) begin
                     alive_in = kw_alive;
                     pos_in   = pos_ff + 3'd1;
                  end else begin
                     alive_in = '0;
                     pos_in   = 3'd0;
                     mode_in  = MODE_IDENT;
                  end
               end else begin
                  take_start = 1'b1;
               end
            end
            MODE_IDENT: begin
               if (is_letter(req_ch))
                  hash_in = hash_step(hash_ff, req_ch);
               else
                  take_start = 1'b1;
            end
            MODE_INT: begin
               if (is_digit(req_ch))
                  num_in = digit_step(num_ff, req_ch);
               else if (req_ch == CH_DOT)
                  mode_in = MODE_DEC;
               else
                  take_start = 1'b1;
            end
            MODE_DEC: begin
               if (!is_digit(req_ch))
                  take_start = 1'b1;
            end
            MODE_SLASH: begin
               if (req_ch == CH_SLASH)
                  mode_in = MODE_COMMENT;
               else
                  take_start = 1'b1;
            end
            MODE_SEMI: begin
               if (req_ch == CH_NEWLINE)
                  go_idle = 1'b1;
               else
                  take_start = 1'b1;
            end
            MODE_COMMENT: begin
               if (req_ch == CH_NEWLINE)
                  go_idle = 1'b1;
            end
            default: begin
               take_start = 1'b1;
            end
         endcase
      end

      if (take_start) begin
         use_flush = 1'b1;
         mode_in   = st_mode;
         alive_in  = st_alive;
         pos_in    = st_pos;
         hash_in   = st_hash;
         num_in    = st_num;
         sec_emit  = st_emit;
         sec_form  = st_form;
         sec_value = OUT_BITS'(st_code);
      end else if (go_idle) begin
         mode_in  = MODE_IDLE;
         alive_in = '0;
         pos_in   = 3'd0;
         hash_in  = HASH_START;
         num_in   = '0;
      end
   end

   // Pack results in order; last goes on the final one
   always_comb begin
      logic first_ok;
      first_ok = use_flush && fl_emit;
      res_a    = '{form: fl_form, value: fl_value, last: !sec_emit};
      res_b    = '{form: sec_form, value: sec_value, last: 1'b1};
      push_n   = 2'd0;
      if (first_ok && sec_emit) begin
         push_n = 2'd2;
      end else if (first_ok) begin
         push_n = 2'd1;
      end else if (sec_emit) begin
         push_n = 2'd1;
         res_a  = res_b;
      end
      if (!req_take)
         push_n = 2'd0;
   end

   // Queue pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff + QPTR_BITS'(push_n);
      rd_ptr_in = rd_ptr_ff + QPTR_BITS'(rsp_take);
      count_in  = count_ff + QCNT_BITS'(push_n) - QCNT_BITS'(rsp_take);
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         alive_ff  <= '0;
         pos_ff    <= 3'd0;
         hash_ff   <= HASH_START;
         num_ff    <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (req_take) begin
            mode_ff  <= mode_in;
            alive_ff <= alive_in;
            pos_ff   <= pos_in;
            hash_ff  <= hash_in;
            num_ff   <= num_in;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage
   always_ff @(posedge clock) begin
      if (push_n != 2'd0)
         queue_ff[wr_ptr_ff] <= res_a;
      if (push_n == 2'd2)
         queue_ff[wr_ptr_ff + QPTR_BITS'(1)] <= res_b;
   end

   assign rsp_valid = count_ff != '0;
   assign rsp_form  = queue_ff[rd_ptr_ff].form;
   assign rsp_value = queue_ff[rd_ptr_ff].value;
   assign rsp_last  = queue_ff[rd_ptr_ff].last;

   // Checks
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_BITS'(QUEUE_DEPTH))
      else $error("result queue overfilled");

   a_end_to_idle: assert property (@(posedge clock) disable iff (reset)
      (req_take && req_ch == CH_END) |=> (mode_ff == MODE_IDLE && hash_ff == HASH_START))
      else $error("end of text did not return lexer to idle");

   a_keyword_alive: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_KEYWORD) |-> (alive_ff != '0))
      else $error("keyword mode with no live keyword");

   // Match position can be zero or one in identifier mode, so only the live mask is checked
   a_no_stray_alive: assert property (@(posedge clock) disable iff (reset)
      (mode_ff != MODE_KEYWORD) |-> (alive_ff == '0))
      else $error("keyword tracking left outside keyword mode");

   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_form == FORM_END) |-> rsp_last)
      else $error("end of text result not marked last");

endmodule
